>>> rtl/cdt_pkg.sv
package cdt_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int CUTOFF_WIDTH = 64;

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W     = 9;
  localparam int UW_W      = 7;
  localparam int DATA_W    = 64;
  localparam int VAL_W     = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 9;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);
  localparam logic [UW_W-1:0]  UW_RESET  = UW_W'(64);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_WIDTH = CFG_IDX_W'(1);

  typedef logic [CUTOFF_WIDTH-1:0] cutoff_t;

  typedef struct packed {
    logic    shift_zero;
    logic    shift_one;
    logic    load_tail;
    cutoff_t tail_data;
  } ring_ctrl_t;

endpackage

>>> rtl/cdt_cell.sv
module cdt_cell
  import cdt_pkg::*;
(
  input  logic    clk,
  input  logic    shift_zero,
  input  logic    shift_one,
  input  cutoff_t in_zero,
  input  cutoff_t in_one,
  output cutoff_t q_zero,
  output cutoff_t q_one
);

  always_ff @(posedge clk) begin
    if (shift_zero) begin
      q_zero <= in_zero;
    end
    if (shift_one) begin
      q_one <= in_one;
    end
  end

endmodule

>>> rtl/cdt_ring.sv
module cdt_ring
  import cdt_pkg::*;
(
  input  logic       clk,
  input  ring_ctrl_t ctrl,
  output cutoff_t    head_zero,
  output cutoff_t    head_one
);

  cutoff_t zq [TABLE_DEPTH];
  cutoff_t oq [TABLE_DEPTH];
  cutoff_t zin [TABLE_DEPTH];
  cutoff_t oin [TABLE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == TABLE_DEPTH - 1) begin : g_tail
        assign zin[i] = ctrl.load_tail ? ctrl.tail_data : zq[0];
        assign oin[i] = ctrl.load_tail ? ctrl.tail_data : oq[0];
      end else begin : g_mid
        assign zin[i] = zq[i+1];
        assign oin[i] = oq[i+1];
      end

      cdt_cell u_cell (
        .clk        (clk),
        .shift_zero (ctrl.shift_zero),
        .shift_one  (ctrl.shift_one),
        .in_zero    (zin[i]),
        .in_one     (oin[i]),
        .q_zero     (zq[i]),
        .q_one      (oq[i])
      );
    end
  endgenerate

  assign head_zero = zq[0];
  assign head_one  = oq[0];

endmodule

>>> rtl/cdt_ctrl.sv
module cdt_ctrl
  import cdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic                    use_zero_table,
  input  logic [DATA_W-1:0]       weight,
  input  logic [DATA_W-1:0]       uniform_bits,
  input  logic                    sign_bit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] sample_value,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  cutoff_t                 head_zero,
  input  cutoff_t                 head_one,
  output ring_ctrl_t              ring_ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam cutoff_t CUT_MAX = {CUTOFF_WIDTH{1'b1}};

  logic [1:0]        state;
  logic [IDX_W-1:0]  step;
  logic              is_sample;
  logic              sel_zero;
  logic              neg;
  logic [DATA_W-1:0] u;
  logic [IDX_W-1:0]  n_last;
  logic              found;
  logic [IDX_W-1:0]  obs;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_pos;
  logic [CNT_W-1:0]  zero_fill;
  logic [CNT_W-1:0]  one_fill;
  cutoff_t           zero_total;
  cutoff_t           one_total;
  logic [LEN_W-1:0]  table_length;
  logic [UW_W-1:0]   uniform_width;

  logic                  accept;
  logic [DATA_W-1:0]     umask;
  cutoff_t               wclip;
  cutoff_t               cur_total;
  logic [CUTOFF_WIDTH:0] sum;
  cutoff_t               sat_total;
  logic [CNT_W-1:0]      cur_fill;
  logic [IDX_W-1:0]      n_last_next;
  cutoff_t               head;
  logic                  hit;
  logic                  last_step;
  logic [IDX_W-1:0]      idx_final;
  logic [VAL_W-1:0]      mag;
  logic [VAL_W-1:0]      result;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      umask[i] = (i < int'(uniform_width));
    end
  end

  assign wclip     = (weight > DATA_W'(CUT_MAX)) ? CUT_MAX : weight[CUTOFF_WIDTH-1:0];
  assign cur_total = use_zero_table ? zero_total : one_total;
  assign sum       = {1'b0, cur_total} + {1'b0, wclip};
  assign sat_total = sum[CUTOFF_WIDTH] ? CUT_MAX : sum[CUTOFF_WIDTH-1:0];
  assign cur_fill  = use_zero_table ? zero_fill : one_fill;

  always_comb begin
    if (table_length == '0) begin
      n_last_next = '0;
    end else if (int'(table_length) > TABLE_DEPTH) begin
      n_last_next = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      n_last_next = IDX_W'(table_length - LEN_W'(1));
    end
  end

  assign head      = sel_zero ? head_zero : head_one;
  assign hit       = !found && (step <= n_last) && (u < DATA_W'(head));
  assign last_step = (step == IDX_W'(TABLE_DEPTH - 1));
  assign idx_final = found ? obs : n_last;
  assign mag       = VAL_W'(idx_final);

  always_comb begin
    if (!neg) begin
      result = mag;
    end else if (sel_zero) begin
      result = VAL_W'(0) - mag;
    end else begin
      result = ~mag;
    end
  end

  always_comb begin
    ring_ctrl.shift_zero = (state == ST_RUN) && sel_zero;
    ring_ctrl.shift_one  = (state == ST_RUN) && !sel_zero;
    ring_ctrl.load_tail  = !is_sample && wr_en && (step == wr_pos);
    ring_ctrl.tail_data  = sel_zero ? zero_total : one_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      zero_fill     <= '0;
      one_fill      <= '0;
      zero_total    <= '0;
      one_total     <= '0;
      table_length  <= LEN_RESET;
      uniform_width <= UW_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TABLE_LENGTH:  table_length  <= cfg_data[LEN_W-1:0];
          CFG_UNIFORM_WIDTH: uniform_width <= cfg_data[UW_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            is_sample <= (action == ACT_SAMPLE);
            sel_zero  <= use_zero_table;
            neg       <= sign_bit;
            u         <= uniform_bits & umask;
            n_last    <= n_last_next;
            step      <= '0;
            found     <= 1'b0;
            wr_en     <= (action == ACT_LOAD) && (cur_fill < CNT_W'(TABLE_DEPTH));
            state     <= ST_RUN;
            if (action == ACT_LOAD) begin
              if (use_zero_table) begin
                zero_total <= sat_total;
              end else begin
                one_total <= sat_total;
              end
              if (cur_fill < CNT_W'(TABLE_DEPTH)) begin
                wr_pos <= cur_fill[IDX_W-1:0];
                if (use_zero_table) begin
                  zero_fill <= zero_fill + CNT_W'(1);
                end else begin
                  one_fill <= one_fill + CNT_W'(1);
                end
              end
            end
          end
        end
        ST_RUN: begin
          step <= step + IDX_W'(1);
          if (is_sample && hit) begin
            found <= 1'b1;
            obs   <= step;
          end
          if (last_step) begin
            state <= is_sample ? ST_HOLD : ST_IDLE;
          end
        end
        ST_HOLD: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            sample_value <= $signed(result);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_HOLD)
    else $error("result issued outside hold state");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_step) |=> (state == ST_IDLE || state == ST_HOLD))
    else $error("ring rotation did not finish after a full turn");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    zero_fill <= CNT_W'(TABLE_DEPTH) && one_fill <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && found) |-> obs <= n_last)
    else $error("hit recorded past table length");

  a_one_ring: assert property (@(posedge clk) disable iff (rst)
    !(ring_ctrl.shift_zero && ring_ctrl.shift_one))
    else $error("both tables rotating at once");

endmodule

>>> rtl/cdt_gaussian_sampler.sv
// Load item: accepted, then one full turn of the cutoff ring; the next item is taken
//   once the turn is over.
// Sample item: accepted, then one full turn of the cutoff ring; the result is registered
//   once the output register is free, and the next item is taken after that.
// Reset (rst, synchronous) clears control, fill counts, running totals and sets
//   table_length to 256 and uniform_width to 64; cutoff cells are not cleared.
module cdt_gaussian_sampler
  import cdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic                    use_zero_table,
  input  logic [DATA_W-1:0]       weight,
  input  logic [DATA_W-1:0]       uniform_bits,
  input  logic                    sign_bit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] sample_value,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  ring_ctrl_t ring_ctrl;
  cutoff_t    head_zero;
  cutoff_t    head_one;

  cdt_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .use_zero_table (use_zero_table),
    .weight         (weight),
    .uniform_bits   (uniform_bits),
    .sign_bit       (sign_bit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_value   (sample_value),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_zero      (head_zero),
    .head_one       (head_one),
    .ring_ctrl      (ring_ctrl)
  );

  cdt_ring u_ring (
    .clk       (clk),
    .ctrl      (ring_ctrl),
    .head_zero (head_zero),
    .head_one  (head_one)
  );

endmodule
